[hdl/swm_pkg.sv]
// Shared constants, codes and types for the star wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Pattern store capacity in bytes
    localparam int MAX_PATTERN = 32;
    // Number of pattern positions, 0 .. MAX_PATTERN
    localparam int POS_N       = MAX_PATTERN + 1;
    // Pattern length and position index width
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    // Pattern store address width
    localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    // Levels of the star closure prefix network
    localparam int CLOS_LEVELS = $clog2(POS_N);
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'd42;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SOURCE = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef logic [POS_N-1:0] pos_set_t;

endpackage

`default_nettype wire

[hdl/star_wildcard_matcher.sv]
// Top level of the star-only wildcard matcher: input stage, position-set logic, result stage.
//
// Usage:
//   Input channel (s_valid / s_ready, s_func, s_char_in) carries one item per handshake:
//   clear pattern, append a pattern byte, a source byte, or end of source string.
//   Result channel (m_valid / m_ready, m_matched, m_pattern_overflow) carries one item
//   for each end item: whether the whole source matched the whole pattern, and whether
//   pattern bytes were dropped because the 32-byte store was full.
//   Result path: an accepted end item is held in the input stage, then registered in
//   the result register, which raises m_valid.
//   Throughput: one item per cycle unless an end item waits on a stalled result.
//   Each source byte updates the live set; the star closure is a six-level prefix network.
//   Stall: while a result waits on m_ready, clear, append and source items keep
//   flowing; a further end item waits in the input stage until the result register
//   frees, and s_ready drops behind it.
//   Reset (aresetn low, synchronous): pattern length zero, overflow flag clear, no
//   string in progress, both stages empty. Stored pattern bytes are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module star_wildcard_matcher
    import swm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_func,
    input  wire logic [BYTE_W-1:0] s_char_in,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_matched,
    output logic                   m_pattern_overflow
);

    // Input stage
    logic              in_valid_reg;
    func_t             in_func_reg;
    logic [BYTE_W-1:0] in_char_reg;

    // Pattern and string state
    logic [BYTE_W-1:0] store_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    pos_set_t          start_reg, start_next;
    pos_set_t          live_reg, live_next;
    logic              in_string_reg, in_string_next;
    logic              ovf_reg, ovf_next;
    logic              store_we;

    // Result stage
    logic              m_valid_reg, m_valid_next;
    logic              m_matched_reg;
    logic              m_ovf_reg;

    logic              res_free;
    logic              proc;
    logic              store_full;
    logic [LEN_W-1:0]  len_inc;
    logic [MAX_PATTERN-1:0] pos_valid;
    pos_set_t          base_set;
    pos_set_t          step_set;
    pos_set_t          prop_set;
    pos_set_t          closed_set;
    logic              match_now;

    // Handshake: an end item needs a free result register
    assign res_free = !m_valid_reg || m_ready;
    assign proc     = in_valid_reg && ((in_func_reg != FUNC_END) || res_free);
    assign s_ready  = !in_valid_reg || proc;

    assign store_full = (len_reg == LEN_W'(MAX_PATTERN));
    assign len_inc    = len_reg + LEN_W'(1);

    // Live set at this item: start set if no string is in progress
    assign base_set  = in_string_reg ? live_reg : start_reg;
    assign match_now = base_set[len_reg];

    // Positions inside the stored pattern
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos_valid[i] = (LEN_W'(i) < len_reg);
        end
    end

    // One source byte step over every live position
    always_comb begin
        step_set = '0;
        prop_set = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (base_set[i] && pos_valid[i]) begin
                if (star_reg[i]) begin
                    step_set[i] = 1'b1;
                end else if (store_reg[i] == in_char_reg) begin
                    step_set[i+1] = 1'b1;
                end
            end
            // a star at i lets position i reach i+1 without a byte
            prop_set[i+1] = pos_valid[i] && star_reg[i];
        end
    end

    // Star closure as a prefix network: out[j] = step[j] | prop[j] & out[j-1]
    always_comb begin
        pos_set_t g_lvl [CLOS_LEVELS+1];
        pos_set_t p_lvl [CLOS_LEVELS+1];
        int       span;
        g_lvl[0] = step_set;
        p_lvl[0] = prop_set;
        for (int lvl = 0; lvl < CLOS_LEVELS; lvl++) begin
            span = 1 << lvl;
            for (int j = 0; j < POS_N; j++) begin
                if (j >= span) begin
                    g_lvl[lvl+1][j] = g_lvl[lvl][j] | (p_lvl[lvl][j] & g_lvl[lvl][j-span]);
                    p_lvl[lvl+1][j] = p_lvl[lvl][j] & p_lvl[lvl][j-span];
                end else begin
                    g_lvl[lvl+1][j] = g_lvl[lvl][j];
                    p_lvl[lvl+1][j] = p_lvl[lvl][j];
                end
            end
        end
        closed_set = g_lvl[CLOS_LEVELS];
    end

    // Next state per item function
    always_comb begin
        len_next       = len_reg;
        start_next     = start_reg;
        live_next      = live_reg;
        in_string_next = in_string_reg;
        ovf_next       = ovf_reg;
        store_we       = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        if (proc) begin
            unique case (in_func_reg)
                FUNC_CLEAR: begin
                    len_next       = '0;
                    start_next     = pos_set_t'(1);
                    ovf_next       = 1'b0;
                    in_string_next = 1'b0;
                    live_next      = '0;
                end
                FUNC_APPEND: begin
                    if (!store_full) begin
                        store_we             = 1'b1;
                        len_next             = len_inc;
                        // start set grows only through a run of leading stars
                        start_next[len_inc]  = start_reg[len_reg] &&
                                               (in_char_reg == STAR_BYTE);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    in_string_next = 1'b0;
                    live_next      = '0;
                end
                FUNC_SOURCE: begin
                    live_next      = closed_set;
                    in_string_next = 1'b1;
                end
                FUNC_END: begin
                    m_valid_next   = 1'b1;
                    in_string_next = 1'b0;
                    live_next      = '0;
                end
                default: begin
                    live_next = live_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            len_reg       <= '0;
            start_reg     <= pos_set_t'(1);
            live_reg      <= '0;
            in_string_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            len_reg       <= len_next;
            start_reg     <= start_next;
            live_reg      <= live_next;
            in_string_reg <= in_string_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_func_reg <= func_t'(s_func);
            in_char_reg <= s_char_in;
        end
        if (store_we) begin
            store_reg[len_reg[ADDR_W-1:0]] <= in_char_reg;
            star_reg[len_reg[ADDR_W-1:0]]  <= (in_char_reg == STAR_BYTE);
        end
        if (proc && (in_func_reg == FUNC_END)) begin
            m_matched_reg <= match_now;
            m_ovf_reg     <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_ovf_reg;

endmodule

`default_nettype wire

[hdl/swm_checker.sv]
// Port-level checker for the star wildcard matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module swm_checker
    import swm_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic [1:0]        s_func,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_matched,
    input wire logic              m_pattern_overflow
);

    logic acc_end;
    logic acc_clear;

    assign acc_end   = s_valid && s_ready && (s_func == FUNC_END);
    assign acc_clear = s_valid && s_ready && (s_func == FUNC_CLEAR);

    // A pending result is held until taken
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result item dropped while stalled");

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A fresh result follows an end item through the input stage and result register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(acc_end, 2))
        else $error("result item without an end item");

    // Empty pattern and empty string match, with no overflow
    a_empty_match: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid) && $past(acc_end, 2) && $past(acc_clear, 3))
            |-> (m_matched && !m_pattern_overflow))
        else $error("empty string failed to match empty pattern");

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (.*);

`default_nettype wire
